// File: src/talu_pkg.sv
package talu_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned RegCount  = 8;
  localparam int unsigned RegAddrW  = 3;
  localparam int unsigned ShiftW    = 8;
  localparam int unsigned ShiftLowW = 5;

  // item kinds
  typedef enum logic [1:0] {
    REQ_ALU        = 2'd0,
    REQ_LOAD_REG   = 2'd1,
    REQ_LOAD_FLAGS = 2'd2
  } req_type_e;

  // thumb format 4 opcodes
  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_LSL = 4'd2,
    OP_LSR = 4'd3,
    OP_ASR = 4'd4,
    OP_ADC = 4'd5,
    OP_SBC = 4'd6,
    OP_ROR = 4'd7,
    OP_TST = 4'd8,
    OP_NEG = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_ORR = 4'd12,
    OP_MUL = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } alu_op_e;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [3:0]           alu_op;
    logic [RegAddrW-1:0]  src_index;
    logic [RegAddrW-1:0]  dst_index;
    logic [DataWidth-1:0] load_value;
  } talu_in_t;

  typedef struct packed {
    logic [DataWidth-1:0] result_value;
    logic                 reg_written;
    logic                 flag_n;
    logic                 flag_z;
    logic                 flag_c;
    logic                 flag_v;
  } talu_out_t;

  // nzcv, n in the top bit
  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } talu_flags_t;

  // execute unit result toward writeback
  typedef struct packed {
    logic [DataWidth-1:0] result;
    logic                 reg_wr;
    talu_flags_t          flags;
  } talu_exec_t;

endpackage

// File: src/talu_regfile.sv
module talu_regfile
  import talu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [RegAddrW-1:0]  ra_addr_i,
  input  logic [RegAddrW-1:0]  rb_addr_i,
  output logic [DataWidth-1:0] ra_data_o,
  output logic [DataWidth-1:0] rb_data_o,
  input  logic                 we_i,
  input  logic [RegAddrW-1:0]  wa_i,
  input  logic [DataWidth-1:0] wd_i
);

  logic [DataWidth-1:0] mem [RegCount];
  logic [RegCount-1:0]  valid_q;
  logic [DataWidth-1:0] ra_q, rb_q;
  logic                 ra_vld_q, rb_vld_q;

  // storage array, no reset
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      ra_q <= mem[ra_addr_i];
      rb_q <= mem[rb_addr_i];
    end
  end

  // written marks, an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      ra_vld_q <= 1'b0;
      rb_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[wa_i] <= 1'b1;
      end
      if (rd_en_i) begin
        ra_vld_q <= valid_q[ra_addr_i];
        rb_vld_q <= valid_q[rb_addr_i];
      end
    end
  end

  assign ra_data_o = ra_vld_q ? ra_q : '0;
  assign rb_data_o = rb_vld_q ? rb_q : '0;

endmodule

// File: src/talu_exec.sv
module talu_exec
  import talu_pkg::*;
(
  input  talu_in_t             item_i,
  input  logic [DataWidth-1:0] rd_i,
  input  logic [DataWidth-1:0] rs_i,
  input  talu_flags_t          flags_i,
  output talu_exec_t           exec_o
);

  logic [ShiftW-1:0]    sh;
  logic [ShiftLowW-1:0] k;
  logic                 sh_zero, sh_big, sh_32;
  logic [DataWidth-1:0] lsl_r, lsr_r, asr_r, ror_r;
  logic [2*DataWidth-1:0] ror_w;
  logic                 lsl_c, lsr_c, ror_c;
  logic [DataWidth-1:0] add_a, add_b, prod;
  logic                 add_cin;
  logic [DataWidth:0]   sum;
  logic                 add_v;
  logic [DataWidth-1:0] r;
  logic                 c, v, wr;

  // barrel shifter on rs[7:0]
  assign sh      = rs_i[ShiftW-1:0];
  assign k       = sh[ShiftLowW-1:0];
  assign sh_zero = (sh == '0);
  assign sh_big  = (sh[ShiftW-1:ShiftLowW] != '0);
  assign sh_32   = (sh == ShiftW'(DataWidth));
  assign lsl_r   = rd_i << k;
  assign lsr_r   = rd_i >> k;
  assign asr_r   = DataWidth'($signed(rd_i) >>> k);
  assign ror_w   = {rd_i, rd_i} >> k;
  assign ror_r   = ror_w[DataWidth-1:0];
  assign lsl_c   = rd_i[ShiftLowW'(6'd32 - {1'b0, k})];
  assign lsr_c   = rd_i[k - ShiftLowW'(1)];
  // rotate by a multiple of 32 wraps the index to bit 31
  assign ror_c   = rd_i[k - ShiftLowW'(1)];

  // shared adder operand select
  always_comb begin
    add_a   = rd_i;
    add_b   = rs_i;
    add_cin = 1'b0;
    unique case (alu_op_e'(item_i.alu_op))
      OP_ADC: add_cin = flags_i.c;
      OP_SBC: begin
        add_b   = ~rs_i;
        add_cin = flags_i.c;
      end
      OP_NEG: begin
        add_a   = '0;
        add_b   = ~rs_i;
        add_cin = 1'b1;
      end
      OP_CMP: begin
        add_b   = ~rs_i;
        add_cin = 1'b1;
      end
      default: add_cin = 1'b0;
    endcase
  end

  assign sum   = {1'b0, add_a} + {1'b0, add_b} + {{DataWidth{1'b0}}, add_cin};
  assign add_v = ~(add_a[DataWidth-1] ^ add_b[DataWidth-1])
                 & (add_a[DataWidth-1] ^ sum[DataWidth-1]);
  assign prod  = DataWidth'(rd_i * rs_i);

  // operation select and flag update
  always_comb begin
    r  = '0;
    c  = flags_i.c;
    v  = flags_i.v;
    wr = 1'b1;
    unique case (alu_op_e'(item_i.alu_op))
      OP_AND: r = rd_i & rs_i;
      OP_EOR: r = rd_i ^ rs_i;
      OP_LSL: begin
        priority if (sh_zero) begin
          r = rd_i;
        end else if (sh_big) begin
          r = '0;
          c = sh_32 ? rd_i[0] : 1'b0;
        end else begin
          r = lsl_r;
          c = lsl_c;
        end
      end
      OP_LSR: begin
        priority if (sh_zero) begin
          r = rd_i;
        end else if (sh_big) begin
          r = '0;
          c = sh_32 ? rd_i[DataWidth-1] : 1'b0;
        end else begin
          r = lsr_r;
          c = lsr_c;
        end
      end
      OP_ASR: begin
        priority if (sh_zero) begin
          r = rd_i;
        end else if (sh_big) begin
          r = {DataWidth{rd_i[DataWidth-1]}};
          c = rd_i[DataWidth-1];
        end else begin
          r = asr_r;
          c = lsr_c;
        end
      end
      OP_ROR: begin
        r = ror_r;
        if (!sh_zero) begin
          c = ror_c;
        end
      end
      OP_ADC, OP_SBC, OP_NEG, OP_CMN: begin
        r = sum[DataWidth-1:0];
        c = sum[DataWidth];
        v = add_v;
        if (alu_op_e'(item_i.alu_op) == OP_CMN) begin
          wr = 1'b0;
        end
      end
      OP_CMP: begin
        r  = sum[DataWidth-1:0];
        c  = sum[DataWidth];
        v  = add_v;
        wr = 1'b0;
      end
      OP_TST: begin
        r  = rd_i & rs_i;
        wr = 1'b0;
      end
      OP_ORR: r = rd_i | rs_i;
      OP_MUL: r = prod;
      OP_BIC: r = rd_i & ~rs_i;
      OP_MVN: r = ~rs_i;
    endcase
  end

  // per item kind outputs
  always_comb begin
    exec_o.result = '0;
    exec_o.reg_wr = 1'b0;
    exec_o.flags  = flags_i;
    unique case (req_type_e'(item_i.req_type))
      REQ_ALU: begin
        exec_o.result  = r;
        exec_o.reg_wr  = wr;
        exec_o.flags.n = r[DataWidth-1];
        exec_o.flags.z = (r == '0);
        exec_o.flags.c = c;
        exec_o.flags.v = v;
      end
      REQ_LOAD_REG: begin
        exec_o.result = item_i.load_value;
        exec_o.reg_wr = 1'b1;
      end
      REQ_LOAD_FLAGS: begin
        exec_o.result = {{(DataWidth-4){1'b0}}, item_i.load_value[3:0]};
        exec_o.flags  = talu_flags_t'(item_i.load_value[3:0]);
      end
      default: exec_o.result = '0;
    endcase
  end

endmodule

// File: src/thumb_alu_register_ops.sv
// result word passes through the execute stage register and the output register
// throughput: one word per cycle while the output is not stalled; the register file
//   memory reads Rd and Rs at the accept edge, writeback as the word leaves execute
// a write landing as the next word reads is forwarded from a bypass register
// reset clears the flags, the register written marks (all registers read 0)
//   and the pipeline valids
module thumb_alu_register_ops
  import talu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  talu_in_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output talu_out_t out_word_o
);

  logic                 in_acc;
  logic                 s1_valid_q;
  talu_in_t             s1_q;
  logic                 s1_adv;
  logic [DataWidth-1:0] ra_data, rb_data, rd_val, rs_val;
  logic                 fwd_en_q;
  logic [RegAddrW-1:0]  fwd_addr_q;
  logic [DataWidth-1:0] fwd_data_q;
  talu_flags_t          flags_q;
  talu_exec_t           ex;
  logic                 wr_en;
  logic                 out_valid_q;
  talu_out_t            out_q;

  assign in_acc     = in_valid_i & ~in_stall_o;
  assign s1_adv     = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign wr_en      = s1_adv & ex.reg_wr;

  // register file memory
  talu_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .ra_addr_i (in_word_i.dst_index),
    .rb_addr_i (in_word_i.src_index),
    .ra_data_o (ra_data),
    .rb_data_o (rb_data),
    .we_i      (wr_en),
    .wa_i      (s1_q.dst_index),
    .wd_i      (ex.result)
  );

  // execute stage word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_word_i;
    end
  end

  // bypass for a write made at the same edge as the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_en_q <= 1'b0;
    end else if (in_acc) begin
      fwd_en_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_addr_q <= s1_q.dst_index;
      fwd_data_q <= ex.result;
    end
  end

  assign rd_val = (fwd_en_q && fwd_addr_q == s1_q.dst_index) ? fwd_data_q : ra_data;
  assign rs_val = (fwd_en_q && fwd_addr_q == s1_q.src_index) ? fwd_data_q : rb_data;

  // alu and item decode
  talu_exec u_exec (
    .item_i  (s1_q),
    .rd_i    (rd_val),
    .rs_i    (rs_val),
    .flags_i (flags_q),
    .exec_o  (ex)
  );

  // status flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (s1_adv) begin
      flags_q <= ex.flags;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.result_value <= ex.result;
      out_q.reg_written  <= ex.reg_wr;
      out_q.flag_n       <= ex.flags.n;
      out_q.flag_z       <= ex.flags.z;
      out_q.flag_c       <= ex.flags.c;
      out_q.flag_v       <= ex.flags.v;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // writes only happen as a word leaves the execute stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (s1_valid_q && s1_adv))
    else $error("register write without a retiring word");

  // a word taken in is in the execute stage next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted word lost before execute");

  // the bypass captures the write made at the accept edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && wr_en) |=> (fwd_en_q && fwd_addr_q == $past(s1_q.dst_index)
                           && fwd_data_q == $past(ex.result)))
    else $error("bypass register missed a same-edge write");

  // a retiring word always reaches the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("retired word not presented");

endmodule

// File: verif/thumb_alu_register_ops_tb.sv
`timescale 1ns / 1ps

module thumb_alu_register_ops_tb;
  import talu_pkg::*;

  // request kind that the block reports but otherwise ignores
  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int unsigned CycleLimit = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  talu_in_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  talu_out_t out_word_o;

  // shadow copy of the register file and nzcv
  logic [DataWidth-1:0] shadow_regs [RegCount];
  talu_flags_t          shadow_flags;

  talu_out_t   alu_results_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;

  thumb_alu_register_ops dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #1 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // add with carry in, giving carry out and signed overflow
  function automatic logic [31:0] add_with_flags(input logic [31:0] a, input logic [31:0] b,
                                                 input logic cin, output logic cout,
                                                 output logic ovf);
    logic [32:0] sum;
    sum  = {1'b0, a} + {1'b0, b} + {32'b0, cin};
    cout = sum[32];
    ovf  = (a[31] == b[31]) && (sum[31] != a[31]);
    return sum[31:0];
  endfunction

  // executes one word on the shadow state and returns the result word
  function automatic talu_out_t run_alu_word(input talu_in_t w);
    talu_out_t   o;
    logic [31:0] rd, rs, r;
    logic [7:0]  amt;
    logic [4:0]  rot;
    logic        c, v, wr;
    o = '0;
    case (w.req_type)
      REQ_ALU: begin
        rd  = shadow_regs[w.dst_index];
        rs  = shadow_regs[w.src_index];
        amt = rs[7:0];
        rot = amt[4:0];
        c   = shadow_flags.c;
        v   = shadow_flags.v;
        wr  = 1'b1;
        r   = '0;
        case (alu_op_e'(w.alu_op))
          OP_AND: r = rd & rs;
          OP_EOR: r = rd ^ rs;
          OP_LSL: begin
            if (amt == 0) r = rd;
            else if (amt < 32) begin
              r = rd << amt;
              c = rd[32 - amt];
            end else begin
              r = '0;
              c = (amt == 32) ? rd[0] : 1'b0;
            end
          end
          OP_LSR: begin
            if (amt == 0) r = rd;
            else if (amt < 32) begin
              r = rd >> amt;
              c = rd[amt - 1];
            end else begin
              r = '0;
              c = (amt == 32) ? rd[31] : 1'b0;
            end
          end
          OP_ASR: begin
            if (amt == 0) r = rd;
            else if (amt < 32) begin
              r = $signed(rd) >>> amt;
              c = rd[amt - 1];
            end else begin
              r = {32{rd[31]}};
              c = rd[31];
            end
          end
          OP_ADC: r = add_with_flags(rd, rs, c, c, v);
          OP_SBC: r = add_with_flags(rd, ~rs, c, c, v);
          OP_ROR: begin
            if (amt == 0) r = rd;
            else if (rot == 0) begin
              r = rd;
              c = rd[31];
            end else begin
              r = (rd >> rot) | (rd << (32 - rot));
              c = rd[rot - 1];
            end
          end
          OP_TST: begin
            r  = rd & rs;
            wr = 1'b0;
          end
          OP_NEG: r = add_with_flags(32'd0, ~rs, 1'b1, c, v);
          OP_CMP: begin
            r  = add_with_flags(rd, ~rs, 1'b1, c, v);
            wr = 1'b0;
          end
          OP_CMN: begin
            r  = add_with_flags(rd, rs, 1'b0, c, v);
            wr = 1'b0;
          end
          OP_ORR: r = rd | rs;
          OP_MUL: r = rd * rs;
          OP_BIC: r = rd & ~rs;
          OP_MVN: r = ~rs;
        endcase
        shadow_flags = '{n: r[31], z: (r == 0), c: c, v: v};
        if (wr) shadow_regs[w.dst_index] = r;
        o.result_value = r;
        o.reg_written  = wr;
      end
      REQ_LOAD_REG: begin
        shadow_regs[w.dst_index] = w.load_value;
        o.result_value = w.load_value;
        o.reg_written  = 1'b1;
      end
      REQ_LOAD_FLAGS: begin
        shadow_flags   = talu_flags_t'(w.load_value[3:0]);
        o.result_value = {28'd0, w.load_value[3:0]};
      end
      default: ;
    endcase
    o.flag_n = shadow_flags.n;
    o.flag_z = shadow_flags.z;
    o.flag_c = shadow_flags.c;
    o.flag_v = shadow_flags.v;
    return o;
  endfunction

  // mostly alu ops, register loads biased toward edge values and shift amounts
  function automatic talu_in_t random_word();
    talu_in_t    w;
    int unsigned pick;
    w.req_type   = REQ_ALU;
    w.alu_op     = 4'($urandom_range(15));
    w.src_index  = 3'($urandom_range(7));
    w.dst_index  = 3'($urandom_range(7));
    w.load_value = $urandom();
    pick = $urandom_range(99);
    if (pick < 22) begin
      w.req_type = REQ_LOAD_REG;
      case ($urandom_range(7))
        0: w.load_value = '0;
        1: w.load_value = '1;
        2: w.load_value = 32'h8000_0000;
        3: w.load_value = 32'h7FFF_FFFF;
        4, 5: begin
          case ($urandom_range(7))
            0: w.load_value[7:0] = 8'd0;
            1: w.load_value[7:0] = 8'd1;
            2: w.load_value[7:0] = 8'd31;
            3: w.load_value[7:0] = 8'd32;
            4: w.load_value[7:0] = 8'd33;
            5: w.load_value[7:0] = 8'd64;
            6: w.load_value[7:0] = 8'd255;
            default: ;
          endcase
        end
        default: ;
      endcase
    end else if (pick < 30) begin
      w.req_type = REQ_LOAD_FLAGS;
    end else if (pick < 32) begin
      w.req_type = ReqUnused;
    end
    return w;
  endfunction

  // offers one word after a random gap and predicts it once taken
  task automatic send_word(input talu_in_t w);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    alu_results_q.push_back(run_alu_word(w));
  endtask

  task automatic send_op(input alu_op_e op, input int src, input int dst);
    talu_in_t w;
    w            = '0;
    w.req_type   = REQ_ALU;
    w.alu_op     = op;
    w.src_index  = 3'(src);
    w.dst_index  = 3'(dst);
    w.load_value = $urandom();
    send_word(w);
  endtask

  task automatic send_load(input int dst, input logic [31:0] value);
    talu_in_t w;
    w            = '0;
    w.req_type   = REQ_LOAD_REG;
    w.alu_op     = 4'($urandom_range(15));
    w.dst_index  = 3'(dst);
    w.load_value = value;
    send_word(w);
  endtask

  task automatic send_flags(input logic [3:0] nzcv);
    talu_in_t w;
    w            = '0;
    w.req_type   = REQ_LOAD_FLAGS;
    w.load_value = {28'($urandom()), nzcv};
    send_word(w);
  endtask

  // sender holds off until every pending result is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (alu_results_q.size() != 0) @(posedge clk_i);
  endtask

  // register loads, every opcode once, plus a flag load and the unused request kind
  task automatic test_all_ops();
    talu_in_t w;
    send_load(0, 32'h8000_0001);
    send_load(1, 32'hFFFF_FFFF);
    send_load(2, 32'h7FFF_FFFF);
    send_flags(4'b1111);
    for (int op = 0; op < 16; op++) send_op(alu_op_e'(op), (op + 1) % 3, op % 3);
    w            = '0;
    w.req_type   = ReqUnused;
    w.load_value = 32'hFFFF_FFFF;
    send_word(w);
  endtask

  // shift by zero, by exactly 32, above 32 and rotate by a multiple of 32
  task automatic test_shift_edges();
    send_load(3, 32'd32);
    send_load(4, 32'h8000_0001);
    send_load(5, 32'h8000_0001);
    send_load(6, 32'h8000_0001);
    send_op(OP_LSL, 3, 4);
    send_op(OP_LSR, 3, 5);
    send_op(OP_ASR, 3, 6);
    // only the low byte counts: 0x140 rotates by 64
    send_load(3, 32'h0000_0140);
    send_load(7, 32'h8000_0001);
    send_op(OP_ROR, 3, 7);
    send_load(3, 32'd33);
    send_load(4, 32'hFFFF_FFFF);
    send_op(OP_LSL, 3, 4);
    send_op(OP_LSR, 3, 7);
    send_load(3, 32'h0000_0100);
    send_op(OP_LSL, 3, 6);
    send_op(OP_ROR, 3, 6);
    wait_drained();
  endtask

  task automatic test_random(input int count, input int unsigned idle_pct,
                             input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_word(random_word());
    wait_drained();
  endtask

  // long receiver hold-off while the sender keeps offering words
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 60;
    repeat (40) send_word(random_word());
    wait_drained();
  endtask

  // receiver stall pattern and hold-off countdown
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // compare each taken result word with the oldest prediction
  always @(posedge clk_i) begin : check_results
    talu_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (alu_results_q.size() == 0) begin
        $error("result word %h with nothing pending", out_word_o);
        mismatch_cnt++;
      end else begin
        want = alu_results_q.pop_front();
        check_field("result_value", want.result_value, out_word_o.result_value);
        check_field("reg_written", 32'(want.reg_written), 32'(out_word_o.reg_written));
        check_field("flag_n", 32'(want.flag_n), 32'(out_word_o.flag_n));
        check_field("flag_z", 32'(want.flag_z), 32'(out_word_o.flag_z));
        check_field("flag_c", 32'(want.flag_c), 32'(out_word_o.flag_c));
        check_field("flag_v", 32'(want.flag_v), 32'(out_word_o.flag_v));
      end
    end
  end

  initial begin
    for (int i = 0; i < RegCount; i++) shadow_regs[i] = '0;
    shadow_flags = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_all_ops();
    test_shift_edges();
    test_random(360, 6, 80);
    test_random(360, 80, 6);
    test_random(360, 0, 0);
    test_backpressure();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
